@@ src/lifo_stack_heap_allocator_core_assert.svh @@
// Assertion macros shared by the allocator checker.
`ifndef LIFO_STACK_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define LIFO_STACK_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSHA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define LSHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed: next-cycle rule");

`endif

@@ src/lsha_pkg.sv @@
// Types and constants shared by the heap allocator modules.
`default_nettype none
package lsha_pkg;

	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned ALIGN_W         = 5;
	localparam logic [ALIGN_W-1:0] WORD_ALIGN_LOG2 = 5'd2;

	// Request codes.
	typedef enum logic [2:0] {
		FN_ALLOC     = 3'd0,
		FN_ALLOC_ALL = 3'd1,
		FN_FREE      = 3'd2,
		FN_FREE_ALL  = 3'd3,
		FN_RESIZE    = 3'd4
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NOT_TOP  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Outcome of a block placement attempt.
	typedef struct packed {
		logic              fits;
		logic [ADDR_W-1:0] addr;
	} place_res_t;

	// One entry of the block stack.
	typedef struct packed {
		logic [ADDR_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
	} stack_entry_t;

endpackage
`default_nettype wire

@@ src/lsha_place.sv @@
// Placement of a block below a top address: subtract, align down, subtract header, check.
`default_nettype none
module lsha_place #(
	parameter int unsigned HEADER_BYTES = 8
) (
	input  logic [31:0]         top,
	input  logic [31:0]         size,
	input  logic [4:0]          alog,
	input  logic [31:0]         region_start,
	output lsha_pkg::place_res_t res
);
	import lsha_pkg::*;

	localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

	logic [ADDR_W-1:0] diff;
	logic [ADDR_W-1:0] mask;
	logic [ADDR_W-1:0] aligned;
	logic [ADDR_W-1:0] hdr_addr;

	// Align the remaining top down and reserve room for the header.
	always_comb begin
		diff     = top - size;
		mask     = ~((ADDR_W'(1) << alog) - ADDR_W'(1));
		aligned  = diff & mask;
		hdr_addr = aligned - HDR;
		res.fits = (size <= top) && (aligned >= HDR) && (hdr_addr >= region_start);
		res.addr = hdr_addr;
	end

endmodule
`default_nettype wire

@@ src/lsha_stack_mem.sv @@
// Block stack storage below the cached top entry, with registered read and write bypass.
`default_nettype none
module lsha_stack_mem #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  lsha_pkg::stack_entry_t      wdata,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output lsha_pkg::stack_entry_t      rdata
);
	import lsha_pkg::*;

	stack_entry_t mem [DEPTH];
	stack_entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; a write to the same entry in this cycle is forwarded.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/lifo_stack_heap_allocator_core.sv @@
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless out_stall holds a result; each request is one placement pass.
// The next-to-top stack entry is prefetched from the stack memory so back-to-back frees keep rate.
// Reset clears the top pointer, block count, region registers and both handshake stages.
// Stack entries are not cleared; only entries written since the last free all are read.
`default_nettype none
module lifo_stack_heap_allocator_core #(
	parameter int unsigned MAX_BLOCKS   = 16,
	parameter int unsigned HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [31:0] request_size,
	input  logic [4:0]  align_log2,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] data_address,
	output logic [31:0] granted_size,
	output logic [31:0] move_length
);
	import lsha_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_TWO = CNT_W'(2);
	localparam logic [ADDR_W-1:0] HDR     = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W:0]   HDR_X   = (ADDR_W + 1)'(HEADER_BYTES);
	localparam logic [ADDR_W:0]   SAT_MAX = {1'b0, {ADDR_W{1'b1}}};

	// Configuration registers.
	logic [ADDR_W-1:0] region_start_q;
	logic [ADDR_W-1:0] region_end_q;

	// Allocator state; the top stack entry is held in registers.
	logic [ADDR_W-1:0] top_q;
	logic [CNT_W-1:0]  count_q;
	stack_entry_t      top_entry_q;

	// Input register stage.
	logic              valid_s1;
	logic [2:0]        func_s1;
	logic [ADDR_W-1:0] size_s1;
	logic [4:0]        align_s1;
	logic [ADDR_W-1:0] baddr_s1;

	// Result register.
	logic              out_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] data_q;
	logic [ADDR_W-1:0] granted_q;
	logic [ADDR_W-1:0] moved_q;

	logic fire;
	logic accept;

	// Combinational results of the item in the input register.
	status_t           status_d;
	logic [ADDR_W-1:0] data_d;
	logic [ADDR_W-1:0] granted_d;
	logic [ADDR_W-1:0] moved_d;
	logic [ADDR_W-1:0] top_d;
	logic [CNT_W-1:0]  count_d;
	stack_entry_t      top_entry_d;
	logic              push;

	logic              is_top;
	logic              all_fits;
	logic [ADDR_W-1:0] all_size;
	logic [ADDR_W-1:0] freed;
	logic [ADDR_W:0]   want;
	logic [ADDR_W-1:0] want_sat;
	logic [ADDR_W-1:0] p_top;
	logic [ADDR_W-1:0] p_size;
	logic [4:0]        p_alog;
	place_res_t        place;

	logic [CNT_W-1:0]  rd_cnt;
	logic [CNT_W-1:0]  wr_cnt;
	stack_entry_t      below_entry;

	// Handshake: the input stage advances whenever the result register can take an item.
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_end_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				region_start_q <= cfg_data;
			end else begin
				region_end_q <= cfg_data;
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			size_s1  <= request_size;
			align_s1 <= align_log2;
			baddr_s1 <= block_address;
		end
	end

	// Operands shared by the requests.
	always_comb begin
		is_top   = (count_q != '0) && ({1'b0, baddr_s1} == ({1'b0, top_q} + HDR_X));
		all_fits = {1'b0, top_q} >= ({1'b0, region_start_q} + HDR_X);
		all_size = top_q - region_start_q - HDR;
		freed    = top_q + top_entry_q.size;
		want     = {1'b0, size_s1} + HDR_X;
		want_sat = (want > SAT_MAX) ? {ADDR_W{1'b1}} : want[ADDR_W-1:0];
	end

	// Placement operand selection.
	always_comb begin
		p_top  = top_q;
		p_size = size_s1;
		p_alog = align_s1;
		if (func_s1 == FN_ALLOC_ALL) begin
			p_size = all_size;
			p_alog = WORD_ALIGN_LOG2;
		end else if (func_s1 == FN_RESIZE) begin
			p_top  = freed;
			p_alog = top_entry_q.align;
		end
	end

	lsha_place #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_place (
		.top          (p_top),
		.size         (p_size),
		.alog         (p_alog),
		.region_start (region_start_q),
		.res          (place)
	);

	// Request decode and next state.
	always_comb begin
		status_d    = ST_OK;
		data_d      = '0;
		granted_d   = '0;
		moved_d     = '0;
		top_d       = top_q;
		count_d     = count_q;
		top_entry_d = top_entry_q;
		push        = 1'b0;
		unique case (func_s1)
			FN_ALLOC, FN_ALLOC_ALL: begin
				if (count_q >= CNT_MAX) begin
					status_d = ST_FULL;
				end else if ((func_s1 == FN_ALLOC_ALL && !all_fits) || !place.fits) begin
					status_d = ST_NO_SPACE;
				end else begin
					push              = 1'b1;
					top_entry_d.size  = top_q - place.addr;
					top_entry_d.align = p_alog;
					count_d           = count_q + CNT_ONE;
					top_d             = place.addr;
					data_d            = place.addr + HDR;
					if (func_s1 == FN_ALLOC_ALL) begin
						granted_d = all_size;
					end
				end
			end
			FN_FREE: begin
				if (!is_top) begin
					status_d = ST_NOT_TOP;
				end else begin
					count_d     = count_q - CNT_ONE;
					top_d       = freed;
					top_entry_d = below_entry;
				end
			end
			FN_FREE_ALL: begin
				top_d   = region_end_q;
				count_d = '0;
			end
			FN_RESIZE: begin
				if (!is_top) begin
					status_d = ST_NOT_TOP;
				end else if (!place.fits) begin
					status_d = ST_NO_SPACE;
				end else begin
					moved_d = (top_entry_q.size < want_sat) ? top_entry_q.size : want_sat;
					top_entry_d.size = freed - place.addr;
					top_d   = place.addr;
					data_d  = place.addr + HDR;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Allocator state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			count_q <= '0;
		end else if (fire) begin
			top_q   <= top_d;
			count_q <= count_d;
		end
	end

	// Cached top entry.
	always_ff @(posedge clk) begin
		if (fire) begin
			top_entry_q <= top_entry_d;
		end
	end

	// Stack memory: a push spills the old top entry, the next-to-top entry is prefetched.
	assign wr_cnt = count_q - CNT_ONE;
	assign rd_cnt = (fire ? count_d : count_q) - CNT_TWO;

	lsha_stack_mem #(
		.DEPTH(MAX_BLOCKS)
	) u_stack (
		.clk   (clk),
		.we    (fire && push && (count_q != '0)),
		.waddr (wr_cnt[IDX_W-1:0]),
		.wdata (top_entry_q),
		.raddr (rd_cnt[IDX_W-1:0]),
		.rdata (below_entry)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_d;
			data_q    <= data_d;
			granted_q <= granted_d;
			moved_q   <= moved_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign data_address = data_q;
	assign granted_size = granted_q;
	assign move_length  = moved_q;

endmodule
`default_nettype wire

@@ src/lsha_checker.sv @@
// Port-level checks on the allocator result channel, bound to the top level.
`default_nettype none
`include "lifo_stack_heap_allocator_core_assert.svh"
module lsha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [31:0] data_address,
	input wire logic [31:0] granted_size,
	input wire logic [31:0] move_length
);
	import lsha_pkg::*;

	// A stalled result stays offered and unchanged.
	`LSHA_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)
	`LSHA_ASSERT_NEXT(a_hold_data, clk, arst_n, out_valid && out_stall, $stable(data_address) && $stable(status))

	// A failed request reports no address, size or copy length.
	`LSHA_ASSERT_IMPLY(a_fail_zero, clk, arst_n, out_valid && (status != ST_OK), (data_address == 32'd0) && (granted_size == 32'd0) && (move_length == 32'd0))

	// A grant or a copy length only comes with a successful placement at a real address.
	`LSHA_ASSERT_IMPLY(a_grant_addr, clk, arst_n, out_valid && ((granted_size != 32'd0) || (move_length != 32'd0)), (status == ST_OK) && (data_address != 32'd0))

endmodule

bind lifo_stack_heap_allocator_core lsha_checker u_lsha_checker (.*);
`default_nettype wire

@@ bench/tb_lifo_stack_heap_allocator_core.sv @@
// Self-checking testbench for the downward-growing LIFO heap allocator core.
module tb_lifo_stack_heap_allocator_core;
	import lsha_pkg::*;

	localparam int unsigned MAX_BLOCKS   = 16;
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned QUIET_LIMIT  = 2000;

	// Configuration register indexes.
	localparam logic REG_REGION_START = 1'b0;
	localparam logic REG_REGION_END   = 1'b1;

	// Request codes that the block treats as no operation.
	localparam logic [2:0] FN_UNUSED_LO = 3'd5;
	localparam logic [2:0] FN_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] request_size;
		logic [4:0]  align_log2;
		logic [31:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_address;
		logic [31:0] granted_size;
		logic [31:0] move_length;
	} res_t;

	// Allocator state: region bounds, top pointer and the block stack.
	typedef struct packed {
		logic [31:0]                 region_lo;
		logic [31:0]                 region_hi;
		logic [31:0]                 top;
		logic [4:0]                  depth;
		logic [MAX_BLOCKS-1:0][31:0] sizes;
		logic [MAX_BLOCKS-1:0][4:0]  aligns;
	} heap_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_REGION_START;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = '0;
	logic [31:0] request_size = '0;
	logic [4:0]  align_log2 = '0;
	logic [31:0] block_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] data_address;
	logic [31:0] granted_size;
	logic [31:0] move_length;

	// The heap as the block sees it, and the heap as the queued items will leave it.
	heap_t       model = '0;
	heap_t       plan = '0;
	req_t        request_queue[$];
	res_t        due_results[$];
	req_t        bus_item;
	res_t        predicted;
	res_t        got;
	int unsigned items_in = 0;
	int unsigned errors = 0;
	int unsigned cycle_no = 0;
	int unsigned quiet = 0;
	int unsigned hold_left = 0;
	bit          held_once = 1'b0;
	wire         calm = (cycle_no >= 1200) && (cycle_no < 1700);

	lifo_stack_heap_allocator_core #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.HEADER_BYTES(HEADER_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.request_size(request_size),
		.align_log2(align_log2),
		.block_address(block_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_address(data_address),
		.granted_size(granted_size),
		.move_length(move_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Header address of a block of the given size placed below top, if it fits.
	function automatic place_res_t place_below(logic [31:0] top, logic [31:0] size,
			logic [4:0] alog, logic [31:0] lo);
		place_res_t p;
		logic [31:0] t;
		p = '0;
		t = (top - size) & ~((32'd1 << alog) - 32'd1);
		if (size <= top && t >= HEADER_BYTES && t - HEADER_BYTES >= lo) begin
			p.fits = 1'b1;
			p.addr = t - HEADER_BYTES;
		end
		return p;
	endfunction

	function automatic bit owns_top(heap_t h, logic [31:0] addr);
		return h.depth != 0 && {1'b0, addr} == {1'b0, h.top} + HEADER_BYTES;
	endfunction

	// Advances the heap by one request and works out the result it gives.
	task automatic apply_request(inout heap_t h, input req_t r, output res_t e);
		logic [31:0] size;
		logic [31:0] freed;
		logic [31:0] top_size;
		logic [32:0] want;
		logic [4:0]  alog;
		logic [3:0]  slot;
		place_res_t  p;
		bit          room;
		e = '0;
		size = r.request_size;
		alog = r.align_log2;
		case (r.func)
			FN_ALLOC, FN_ALLOC_ALL: begin
				room = 1'b1;
				// Alloc all claims everything between the top and the region start.
				if (r.func == FN_ALLOC_ALL) begin
					alog = WORD_ALIGN_LOG2;
					if ({1'b0, h.top} < {1'b0, h.region_lo} + HEADER_BYTES)
						room = 1'b0;
					else
						size = h.top - h.region_lo - HEADER_BYTES;
				end
				p = place_below(h.top, size, alog, h.region_lo);
				if (h.depth >= MAX_BLOCKS) begin
					e.status = ST_FULL;
				end else if (!room || !p.fits) begin
					e.status = ST_NO_SPACE;
				end else begin
					h.sizes[h.depth[3:0]] = h.top - p.addr;
					h.aligns[h.depth[3:0]] = alog;
					h.depth = h.depth + 5'd1;
					h.top = p.addr;
					e.data_address = p.addr + HEADER_BYTES;
					if (r.func == FN_ALLOC_ALL)
						e.granted_size = size;
				end
			end
			FN_FREE: begin
				if (!owns_top(h, r.block_address)) begin
					e.status = ST_NOT_TOP;
				end else begin
					h.depth = h.depth - 5'd1;
					h.top = h.top + h.sizes[h.depth[3:0]];
				end
			end
			FN_FREE_ALL: begin
				h.top = h.region_hi;
				h.depth = '0;
			end
			FN_RESIZE: begin
				if (!owns_top(h, r.block_address)) begin
					e.status = ST_NOT_TOP;
				end else begin
					// The top block is re-placed from the address where it ends.
					slot = h.depth[3:0] - 4'd1;
					top_size = h.sizes[slot];
					freed = h.top + top_size;
					p = place_below(freed, size, h.aligns[slot], h.region_lo);
					if (!p.fits) begin
						e.status = ST_NO_SPACE;
					end else begin
						want = {1'b0, size} + HEADER_BYTES;
						if (want[32])
							want = 33'h0_FFFF_FFFF;
						e.move_length = ({1'b0, top_size} < want) ? top_size : want[31:0];
						h.sizes[slot] = freed - p.addr;
						h.top = p.addr;
						e.data_address = p.addr + HEADER_BYTES;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic req_t make_req(logic [2:0] f, logic [31:0] size, logic [4:0] alog,
			logic [31:0] addr);
		req_t r;
		r.func = f;
		r.request_size = size;
		r.align_log2 = alog;
		r.block_address = addr;
		return r;
	endfunction

	// Sizes are mostly small, sometimes up to the space left, sometimes anything.
	function automatic logic [31:0] pick_size(logic [31:0] room);
		int unsigned p;
		p = $urandom_range(99);
		if (p < 60)
			return $urandom_range(48);
		if (p < 85)
			return $urandom_range(room);
		return $urandom;
	endfunction

	// Mostly the data address of the top block, sometimes a near miss or noise.
	function automatic logic [31:0] pick_address();
		logic [31:0] top_data;
		top_data = plan.top + HEADER_BYTES;
		case ($urandom_range(9))
			0: return $urandom;
			1: return top_data ^ (32'd1 << $urandom_range(31));
			default: return top_data;
		endcase
	endfunction

	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		logic [31:0] room;
		r = make_req(FN_ALLOC, $urandom, 5'($urandom_range(31)), $urandom);
		room = (plan.top > plan.region_lo) ? plan.top - plan.region_lo : 32'd0;
		pick = $urandom_range(99);
		if (pick < 32) begin
			r.request_size = pick_size(room);
			case ($urandom_range(9))
				0: r.align_log2 = 5'($urandom_range(31));
				1, 2: r.align_log2 = 5'($urandom_range(12));
				default: r.align_log2 = 5'($urandom_range(4));
			endcase
		end else if (pick < 40) begin
			r.func = FN_ALLOC_ALL;
		end else if (pick < 62) begin
			r.func = FN_FREE;
			r.block_address = pick_address();
		end else if (pick < 68) begin
			r.func = FN_FREE_ALL;
		end else if (pick < 88) begin
			r.func = FN_RESIZE;
			r.request_size = pick_size(room);
			r.block_address = pick_address();
		end else if (pick < 94) begin
			r.func = $urandom_range(1) ? FN_FREE : FN_RESIZE;
		end else begin
			r.func = 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
		end
		return r;
	endfunction

	task automatic queue_req(input req_t r);
		res_t ignored;
		apply_request(plan, r, ignored);
		request_queue.push_back(r);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_REGION_START) begin
			model.region_lo = value;
			plan.region_lo = value;
		end else begin
			model.region_hi = value;
			plan.region_hi = value;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Returns once every queued item has been accepted and answered.
	task automatic wait_idle();
		@(negedge clk);
		while (request_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
			input int unsigned count, input bit clear);
		wait_idle();
		write_reg(REG_REGION_START, lo);
		write_reg(REG_REGION_END, hi);
		if (clear)
			queue_req(make_req(FN_FREE_ALL, $urandom, 5'($urandom_range(31)), $urandom));
		repeat (count) queue_req(random_req());
	endtask

	// Request driver: a new item goes out only when the bus is free.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
				bus_item = request_queue.pop_front();
				in_valid <= 1'b1;
				func <= bus_item.func;
				request_size <= bus_item.request_size;
				align_log2 <= bus_item.align_log2;
				block_address <= bus_item.block_address;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, one forced long hold and a few random ones.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held_once && items_in >= 600) begin
			held_once <= 1'b1;
			hold_left <= 80;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(399) == 0) begin
			hold_left <= $urandom_range(90, 30);
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 14);
		end
	end

	// Monitor: predict on each accepted item, compare each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_request(model, {func, request_size, align_log2, block_address}, predicted);
				due_results.push_back(predicted);
				items_in <= items_in + 1;
			end
			if (out_valid && !out_stall) begin
				got = {status, data_address, granted_size, move_length};
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Result with no item pending: status %0d data %h granted %h move %h",
							got.status, got.data_address, got.granted_size, got.move_length);
				end else begin
					predicted = due_results.pop_front();
					if (got !== predicted) begin
						errors++;
						if (errors <= 10) begin
							$display("Expected status %0d data %h granted %h move %h",
								predicted.status, predicted.data_address,
								predicted.granted_size, predicted.move_length);
							$display("  actual status %0d data %h granted %h move %h",
								got.status, got.data_address, got.granted_size, got.move_length);
						end
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [31:0] base;

		// Reset register values: empty region with the top pointer at zero.
		queue_req(make_req(FN_UNUSED_LO, '0, '0, '0));
		queue_req(make_req(FN_UNUSED_HI, '1, '1, '1));
		queue_req(make_req(FN_ALLOC, '0, '0, '0));
		queue_req(make_req(FN_ALLOC_ALL, '0, '0, '0));
		queue_req(make_req(FN_FREE, '0, '0, HEADER_BYTES));
		queue_req(make_req(FN_RESIZE, 32'd16, '0, HEADER_BYTES));
		queue_req(make_req(FN_FREE_ALL, '0, '0, '0));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: wraps, alignment to zero, resize both ways, stack full.
		wait_idle();
		write_reg(REG_REGION_START, 32'h0000_1000);
		write_reg(REG_REGION_END, 32'h0000_2000);
		queue_req(make_req(FN_FREE_ALL, '0, '0, '0));
		queue_req(make_req(FN_ALLOC, 32'h40, 5'd4, '0));
		queue_req(make_req(FN_ALLOC, '1, '0, '0));
		queue_req(make_req(FN_ALLOC, '0, 5'd31, '0));
		queue_req(make_req(FN_RESIZE, 32'h20, '0, plan.top + HEADER_BYTES + 32'd4));
		queue_req(make_req(FN_RESIZE, 32'h80, '0, plan.top + HEADER_BYTES));
		queue_req(make_req(FN_RESIZE, '1, '0, plan.top + HEADER_BYTES));
		repeat (MAX_BLOCKS - 2) queue_req(make_req(FN_ALLOC, 32'd1, '0, '0));
		queue_req(make_req(FN_ALLOC_ALL, '0, '0, '0));
		queue_req(make_req(FN_ALLOC, '0, '0, '0));
		queue_req(make_req(FN_ALLOC_ALL, '0, '0, '0));
		queue_req(make_req(FN_FREE, '0, '0, plan.top + HEADER_BYTES));
		queue_req(make_req(FN_ALLOC, 32'h0001_0000, '0, '0));

		// Random traffic over a range of region settings, extremes included.
		run_phase(32'h0000_1000, 32'h0000_1800, 270, 1'b1);
		run_phase('0, '1, 270, 1'b1);
		run_phase(32'hFFFF_F000, '1, 270, 1'b1);
		base = $urandom_range(32'h7FFF_0000);
		run_phase(base, base + $urandom_range(600, 16), 270, 1'b1);
		run_phase(32'h0000_0040, 32'h0000_0020, 120, 1'b1);
		run_phase('1, '0, 60, 1'b1);
		base = $urandom_range(32'h7FFF_0000);
		run_phase(base, base + $urandom_range(8192, 256), 270, 1'b1);
		// New bounds without a free all: the top pointer stays where it was.
		run_phase(32'h0000_1000, 32'h0000_2000, 270, 1'b0);

		wait_idle();
		errors += due_results.size();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/lsha_pkg.sv
src/lsha_place.sv
src/lsha_stack_mem.sv
src/lifo_stack_heap_allocator_core.sv
src/lsha_checker.sv
bench/tb_lifo_stack_heap_allocator_core.sv
